>>> hw/rtl/tgcd_pkg.sv
package tgcd_pkg;

    // Frame and arithmetic sizing
    localparam int unsigned MAX_ATOMS_PER_FRAME = 1048576;
    localparam int unsigned COORD_W = 32;
    localparam int unsigned CNT_W   = $clog2(MAX_ATOMS_PER_FRAME + 1);
    localparam int unsigned SUM_W   = COORD_W + $clog2(MAX_ATOMS_PER_FRAME);
    localparam int unsigned DIST_W  = 33;
    localparam int unsigned SQ_W    = 65;
    localparam int unsigned SSUM_W  = 66;
    localparam int unsigned ROOT_W  = 34;
    localparam int unsigned DCNT_W  = $clog2(SUM_W + 1);
    localparam int unsigned RCNT_W  = $clog2(ROOT_W + 1);

    // Register indexes of the configuration port
    localparam logic [1:0] REG_FIRST_TYPE  = 2'd0;
    localparam logic [1:0] REG_SECOND_TYPE = 2'd1;
    localparam logic [1:0] REG_FRAMES      = 2'd2;

    // Status codes
    localparam logic [1:0] ST_FIRST_EMPTY  = 2'b01;
    localparam logic [1:0] ST_SECOND_EMPTY = 2'b10;

    typedef struct packed {
        logic [7:0]  first_type;
        logic [7:0]  second_type;
        logic [31:0] frames_to_scan;
    } cfg_t;

    // One closed frame handed from the accumulator to the result engine
    typedef struct packed {
        logic [31:0]                frame_index;
        logic [5:0][SUM_W-1:0]      sums;
        logic [CNT_W-1:0]           first_cnt;
        logic [CNT_W-1:0]           second_cnt;
    } frame_rec_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_DIV,
        BK_DIFF,
        BK_SQ,
        BK_SUM1,
        BK_SUM2,
        BK_SQRT,
        BK_OUT
    } back_state_t;

endpackage

>>> hw/rtl/two_group_centroid_distance_unit.sv
// Input side takes one atom per cycle; it stalls only while the queue holds two closed frames.
// The result engine works each closed frame through six 52-step serial divisions,
// three squares, two sum steps and four 34-step square roots.
// Reset (rst_n low, asynchronous) clears sums, counts, frame counter, queue and
// output valid, and loads the group types 1 and 2 and the largest frame count, 32'hFFFF_FFFF.
module two_group_centroid_distance_unit (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic [1:0]    cfg_addr,
    input  logic [31:0]   cfg_wdata,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [103:0]  s_tdata,   // atom_type, x_coord, y_coord, z_coord
    input  logic          s_tlast,   // last_in_frame
    output logic          m_tvalid,
    input  logic          m_tready,
    // frame_index, first_cx, first_cy, first_cz, second_cx, second_cy, second_cz,
    // dist_xyz, dist_xy, dist_xz, dist_yz, status
    output logic [359:0]  m_tdata
);

    tgcd_pkg::cfg_t        cfg_reg;
    tgcd_pkg::frame_rec_t  wr_rec, rd_rec;
    tgcd_pkg::q_status_t   qs;
    logic                  push, pop;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.first_type     <= 8'd1;
            cfg_reg.second_type    <= 8'd2;
            cfg_reg.frames_to_scan <= 32'hFFFF_FFFF;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                tgcd_pkg::REG_FIRST_TYPE:  cfg_reg.first_type     <= cfg_wdata[7:0];
                tgcd_pkg::REG_SECOND_TYPE: cfg_reg.second_type    <= cfg_wdata[7:0];
                tgcd_pkg::REG_FRAMES:      cfg_reg.frames_to_scan <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign s_tready = !qs.full;

    tgcd_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .accept        (s_tvalid && s_tready),
        .atom_type     (s_tdata[7:0]),
        .x_coord       (s_tdata[39:8]),
        .y_coord       (s_tdata[71:40]),
        .z_coord       (s_tdata[103:72]),
        .last_in_frame (s_tlast),
        .push          (push),
        .rec           (wr_rec)
    );

    tgcd_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .wr_rec (wr_rec),
        .pop    (pop),
        .rd_rec (rd_rec),
        .status (qs)
    );

    tgcd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .rec       (rd_rec),
        .qs        (qs),
        .pop       (pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );

    a_queue_sane: assert property (@(posedge clk) disable iff (!rst_n)
        !(qs.full && qs.empty))
        else $error("queue both full and empty");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !qs.full)
        else $error("frame closed into a full queue");

    a_proj_le_3d: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[289:257] <= m_tdata[256:224]))
        else $error("projected distance exceeds 3D distance");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[356]) |-> (m_tdata[127:32] == 96'd0))
        else $error("empty first group with nonzero centroid");

endmodule

>>> hw/rtl/tgcd_front.sv
module tgcd_front (
    input  logic                      clk,
    input  logic                      rst_n,
    input  tgcd_pkg::cfg_t            cfg,
    input  logic                      accept,
    input  logic [7:0]                atom_type,
    input  logic [31:0]               x_coord,
    input  logic [31:0]               y_coord,
    input  logic [31:0]               z_coord,
    input  logic                      last_in_frame,
    output logic                      push,
    output tgcd_pkg::frame_rec_t      rec
);

    localparam int unsigned SW = tgcd_pkg::SUM_W;
    localparam int unsigned CW = tgcd_pkg::CNT_W;

    logic [5:0][SW-1:0] sum_reg, sum_next;
    logic [CW-1:0]      cnt1_reg, cnt1_next, cnt2_reg, cnt2_next;
    logic [31:0]        frame_reg;
    logic               live;
    logic               take1, take2;
    logic [2:0][SW-1:0] pos;

    // Widen coordinates to sum width
    assign pos[0] = SW'(signed'(x_coord));
    assign pos[1] = SW'(signed'(y_coord));
    assign pos[2] = SW'(signed'(z_coord));

    assign live  = accept && (frame_reg < cfg.frames_to_scan);
    assign take1 = live && (atom_type == cfg.first_type)
                   && (cnt1_reg < CW'(tgcd_pkg::MAX_ATOMS_PER_FRAME));
    assign take2 = live && (atom_type != cfg.first_type)
                   && (atom_type == cfg.second_type)
                   && (cnt2_reg < CW'(tgcd_pkg::MAX_ATOMS_PER_FRAME));

    // Accumulate matching atoms
    always_comb
    begin
        sum_next  = sum_reg;
        cnt1_next = cnt1_reg;
        cnt2_next = cnt2_reg;
        for (int i = 0; i < 3; i++)
        begin
            if (take1)
                sum_next[i] = sum_reg[i] + pos[i];
            if (take2)
                sum_next[i+3] = sum_reg[i+3] + pos[i];
        end
        if (take1)
            cnt1_next = cnt1_reg + 1'b1;
        if (take2)
            cnt2_next = cnt2_reg + 1'b1;
    end

    assign push            = live && last_in_frame;
    assign rec.frame_index = frame_reg;
    assign rec.sums        = sum_next;
    assign rec.first_cnt   = cnt1_next;
    assign rec.second_cnt  = cnt2_next;

    // Hold sums, clear them when a frame closes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg   <= '0;
            cnt1_reg  <= '0;
            cnt2_reg  <= '0;
            frame_reg <= '0;
        end
        else if (push)
        begin
            sum_reg   <= '0;
            cnt1_reg  <= '0;
            cnt2_reg  <= '0;
            frame_reg <= frame_reg + 1'b1;
        end
        else if (live)
        begin
            sum_reg  <= sum_next;
            cnt1_reg <= cnt1_next;
            cnt2_reg <= cnt2_next;
        end
    end

endmodule

>>> hw/rtl/tgcd_queue.sv
module tgcd_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  tgcd_pkg::frame_rec_t   wr_rec,
    input  logic                   pop,
    output tgcd_pkg::frame_rec_t   rd_rec,
    output tgcd_pkg::q_status_t    status
);

    tgcd_pkg::frame_rec_t mem_reg [2];
    logic                 wr_ptr_reg, rd_ptr_reg;
    logic [1:0]           cnt_reg;

    assign rd_rec       = mem_reg[rd_ptr_reg];
    assign status.full  = (cnt_reg == 2'd2);
    assign status.empty = (cnt_reg == 2'd0);

    // Store closed frames
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= wr_rec;
    end

    // Advance pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            if (push && !pop)
                cnt_reg <= cnt_reg + 2'd1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 2'd1;
        end
    end

endmodule

>>> hw/rtl/tgcd_back.sv
module tgcd_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  tgcd_pkg::frame_rec_t   rec,
    input  tgcd_pkg::q_status_t    qs,
    output logic                   pop,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [359:0]           out_data
);

    localparam int unsigned SW = tgcd_pkg::SUM_W;
    localparam int unsigned CW = tgcd_pkg::CNT_W;
    localparam int unsigned RW = tgcd_pkg::ROOT_W;

    tgcd_pkg::back_state_t state_reg, state_next;

    logic [2:0]                  k_reg, k_next;
    logic [tgcd_pkg::DCNT_W-1:0] bit_reg, bit_next;
    logic [CW-1:0]               rem_reg, rem_next;
    logic [SW-1:0]               quo_reg, quo_next;
    logic                        neg_reg, neg_next;
    logic [5:0][31:0]            cent_reg;
    logic [2:0][32:0]            mag_reg;
    logic [2:0][tgcd_pkg::SQ_W-1:0]   sq_reg;
    logic [3:0][tgcd_pkg::SSUM_W-1:0] ss_reg;
    logic [1:0]                  j_reg, j_next;
    logic [tgcd_pkg::RCNT_W-1:0] it_reg, it_next;
    logic [2*RW-1:0]             op_reg, op_next;
    logic [RW+2:0]               srem_reg, srem_next;
    logic [RW-1:0]               root_reg, root_next;
    logic [3:0][32:0]            dist_reg;
    logic                        ov_reg;
    logic [359:0]                od_reg;

    logic                        div_load, div_step, cent_we, diff_we, sq_we;
    logic                        sum1_we, sum2_we, rt_load, rt_step, dist_we, out_load;
    logic [CW-1:0]               div_cnt;
    logic [CW:0]                 dshift, dtrial;
    logic [31:0]                 cent_val;
    logic [RW+2:0]               rshift, rtrial;
    logic [1:0]                  st;

    // Pick the count for the current division
    always_comb
    begin
        div_cnt = (k_reg < 3'd3) ? rec.first_cnt : rec.second_cnt;
    end

    assign dshift = {rem_reg, quo_reg[SW-1]};
    assign dtrial = dshift - {1'b0, div_cnt};

    assign cent_val = (div_cnt == '0) ? 32'd0 :
                      (neg_reg ? (32'd0 - quo_reg[31:0]) : quo_reg[31:0]);

    assign rshift = {srem_reg[RW:0], op_reg[2*RW-1 -: 2]};
    assign rtrial = rshift - {1'b0, root_reg, 2'b01};

    assign st = ((rec.first_cnt == '0) ? tgcd_pkg::ST_FIRST_EMPTY : 2'b00)
              | ((rec.second_cnt == '0) ? tgcd_pkg::ST_SECOND_EMPTY : 2'b00);

    // Sequence the division, square, sum and root steps
    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        j_next     = j_reg;
        div_load   = 1'b0;
        div_step   = 1'b0;
        cent_we    = 1'b0;
        diff_we    = 1'b0;
        sq_we      = 1'b0;
        sum1_we    = 1'b0;
        sum2_we    = 1'b0;
        rt_load    = 1'b0;
        rt_step    = 1'b0;
        dist_we    = 1'b0;
        out_load   = 1'b0;
        pop        = 1'b0;
        case (state_reg)
            tgcd_pkg::BK_IDLE:
            begin
                if (!qs.empty)
                begin
                    k_next     = 3'd0;
                    div_load   = 1'b1;
                    state_next = tgcd_pkg::BK_DIV;
                end
            end
            tgcd_pkg::BK_DIV:
            begin
                if (bit_reg != '0)
                    div_step = 1'b1;
                else
                begin
                    cent_we = 1'b1;
                    if (k_reg == 3'd5)
                        state_next = tgcd_pkg::BK_DIFF;
                    else
                    begin
                        k_next   = k_reg + 3'd1;
                        div_load = 1'b1;
                    end
                end
            end
            tgcd_pkg::BK_DIFF:
            begin
                diff_we    = 1'b1;
                k_next     = 3'd0;
                state_next = tgcd_pkg::BK_SQ;
            end
            tgcd_pkg::BK_SQ:
            begin
                sq_we = 1'b1;
                if (k_reg == 3'd2)
                    state_next = tgcd_pkg::BK_SUM1;
                else
                    k_next = k_reg + 3'd1;
            end
            tgcd_pkg::BK_SUM1:
            begin
                sum1_we    = 1'b1;
                state_next = tgcd_pkg::BK_SUM2;
            end
            tgcd_pkg::BK_SUM2:
            begin
                sum2_we    = 1'b1;
                j_next     = 2'd0;
                rt_load    = 1'b1;
                state_next = tgcd_pkg::BK_SQRT;
            end
            tgcd_pkg::BK_SQRT:
            begin
                if (it_reg != '0)
                    rt_step = 1'b1;
                else
                begin
                    dist_we = 1'b1;
                    if (j_reg == 2'd3)
                        state_next = tgcd_pkg::BK_OUT;
                    else
                    begin
                        j_next  = j_reg + 2'd1;
                        rt_load = 1'b1;
                    end
                end
            end
            tgcd_pkg::BK_OUT:
            begin
                if (!ov_reg || out_ready)
                begin
                    out_load   = 1'b1;
                    pop        = 1'b1;
                    state_next = tgcd_pkg::BK_IDLE;
                end
            end
            default:
                state_next = tgcd_pkg::BK_IDLE;
        endcase
    end

    // Divider and root datapath next values
    always_comb
    begin
        bit_next  = bit_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        neg_next  = neg_reg;
        it_next   = it_reg;
        op_next   = op_reg;
        srem_next = srem_reg;
        root_next = root_reg;
        if (div_load)
        begin
            neg_next = rec.sums[k_next][SW-1];
            quo_next = rec.sums[k_next][SW-1] ? (SW'(0) - rec.sums[k_next])
                                               : rec.sums[k_next];
            rem_next = '0;
            bit_next = tgcd_pkg::DCNT_W'(SW);
        end
        else if (div_step)
        begin
            bit_next = bit_reg - 1'b1;
            if (!dtrial[CW])
            begin
                rem_next = dtrial[CW-1:0];
                quo_next = {quo_reg[SW-2:0], 1'b1};
            end
            else
            begin
                rem_next = dshift[CW-1:0];
                quo_next = {quo_reg[SW-2:0], 1'b0};
            end
        end
        if (rt_load)
        begin
            op_next   = (2*RW)'(sum2_we ? (ss_reg[1] + {1'b0, sq_reg[2]})
                                        : ss_reg[j_next]);
            srem_next = '0;
            root_next = '0;
            it_next   = tgcd_pkg::RCNT_W'(RW);
        end
        else if (rt_step)
        begin
            it_next = it_reg - 1'b1;
            op_next = {op_reg[2*RW-3:0], 2'b00};
            if (!rtrial[RW+2])
            begin
                srem_next = rtrial;
                root_next = {root_reg[RW-2:0], 1'b1};
            end
            else
            begin
                srem_next = rshift;
                root_next = {root_reg[RW-2:0], 1'b0};
            end
        end
    end

    // Hold the datapath registers
    always_ff @(posedge clk)
    begin
        bit_reg  <= bit_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        neg_reg  <= neg_next;
        it_reg   <= it_next;
        op_reg   <= op_next;
        srem_reg <= srem_next;
        root_reg <= root_next;
        if (cent_we)
            cent_reg[k_reg] <= cent_val;
        if (diff_we)
        begin
            for (int i = 0; i < 3; i++)
            begin
                logic [32:0] d;
                d = {cent_reg[i][31], cent_reg[i]} - {cent_reg[i+3][31], cent_reg[i+3]};
                mag_reg[i] <= d[32] ? (33'd0 - d) : d;
            end
        end
        if (sq_we)
            sq_reg[k_reg[1:0]] <= tgcd_pkg::SQ_W'(mag_reg[k_reg[1:0]] * mag_reg[k_reg[1:0]]);
        if (sum1_we)
        begin
            ss_reg[1] <= {1'b0, sq_reg[0]} + {1'b0, sq_reg[1]};
            ss_reg[2] <= {1'b0, sq_reg[0]} + {1'b0, sq_reg[2]};
            ss_reg[3] <= {1'b0, sq_reg[1]} + {1'b0, sq_reg[2]};
        end
        if (sum2_we)
            ss_reg[0] <= ss_reg[1] + {1'b0, sq_reg[2]};
        if (dist_we)
            dist_reg[j_reg] <= root_reg[32:0];
        if (out_load)
            od_reg <= {2'b00, st, dist_reg[3], dist_reg[2], dist_reg[1], dist_reg[0],
                       cent_reg[5], cent_reg[4], cent_reg[3],
                       cent_reg[2], cent_reg[1], cent_reg[0], rec.frame_index};
    end

    // Control state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tgcd_pkg::BK_IDLE;
            k_reg     <= 3'd0;
            j_reg     <= 2'd0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            j_reg     <= j_next;
            if (out_load)
                ov_reg <= 1'b1;
            else if (out_ready)
                ov_reg <= 1'b0;
        end
    end

    assign out_valid = ov_reg;
    assign out_data  = od_reg;

endmodule
